>>> sv/tzpm_pkg.sv
// ----------------------------------------------------------------------------
// Touch zone pad mapper package
// Shared types, codes and the zone layout table.
// ----------------------------------------------------------------------------
package tzpm_pkg;

	localparam int ZONE_COUNT = 14;

	typedef enum logic [1:0] {
		OP_DOWN   = 2'd0,
		OP_MOTION = 2'd1,
		OP_UP     = 2'd2,
		OP_OTHER  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		XB_ZERO = 2'd0,
		XB_FULL = 2'd1,
		XB_HALF = 2'd2
	} xbase_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_EXTPAD = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_WRITE,
		ST_ZONE,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		xbase_t             xbase;
		logic signed [12:0] xk;
		logic               ybase;
		logic signed [12:0] yk;
		logic               rnd;
		logic [9:0]         hw;
		logic [9:0]         hh;
		logic [15:0]        bitm;
	} zone_t;

	typedef struct packed {
		logic [25:0] w10k;
		logic [24:0] w5k;
		logic [25:0] h10k;
		logic [11:0] m;
	} geo_t;

	typedef struct packed {
		logic               v;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [25:0]        hw;
		logic [25:0]        hh;
		logic               rnd;
		logic [15:0]        bitm;
	} zs1_t;

	typedef struct packed {
		logic        v;
		logic        rnd;
		logic [15:0] bitm;
		logic [51:0] r2;
	} zs3_t;

	typedef struct packed {
		logic pos;
		logic ident;
		logic set_act;
		logic clr_act;
	} wr_t;

	function automatic zone_t zone_get(input logic [3:0] idx);
		zone_t z;
		z = '0;
		case (idx)
			4'd0:  z = '{XB_ZERO,  13'sd1600, 1'b1, -13'sd2650, 1'b1, 10'd621, 10'd621, 16'h0010};
			4'd1:  z = '{XB_ZERO,  13'sd1600, 1'b1,  -13'sd950, 1'b1, 10'd621, 10'd621, 16'h0040};
			4'd2:  z = '{XB_ZERO,   13'sd750, 1'b1, -13'sd1800, 1'b1, 10'd621, 10'd621, 16'h0080};
			4'd3:  z = '{XB_ZERO,  13'sd2450, 1'b1, -13'sd1800, 1'b1, 10'd621, 10'd621, 16'h0020};
			4'd4:  z = '{XB_FULL, -13'sd1600, 1'b1, -13'sd2650, 1'b1, 10'd621, 10'd621, 16'h1000};
			4'd5:  z = '{XB_FULL, -13'sd1600, 1'b1,  -13'sd950, 1'b1, 10'd621, 10'd621, 16'h4000};
			4'd6:  z = '{XB_FULL, -13'sd2450, 1'b1, -13'sd1800, 1'b1, 10'd621, 10'd621, 16'h8000};
			4'd7:  z = '{XB_FULL,  -13'sd750, 1'b1, -13'sd1800, 1'b1, 10'd621, 10'd621, 16'h2000};
			4'd8:  z = '{XB_ZERO,   13'sd950, 1'b0,  13'sd1250, 1'b0, 10'd700, 10'd320, 16'h0400};
			4'd9:  z = '{XB_ZERO,   13'sd950, 1'b0,   13'sd500, 1'b0, 10'd700, 10'd320, 16'h0100};
			4'd10: z = '{XB_FULL,  -13'sd950, 1'b0,  13'sd1250, 1'b0, 10'd700, 10'd320, 16'h0800};
			4'd11: z = '{XB_FULL,  -13'sd950, 1'b0,   13'sd500, 1'b0, 10'd700, 10'd320, 16'h0200};
			4'd12: z = '{XB_HALF,   13'sd800, 1'b1,  -13'sd400, 1'b0, 10'd550, 10'd240, 16'h0008};
			4'd13: z = '{XB_HALF,  -13'sd800, 1'b1,  -13'sd400, 1'b0, 10'd550, 10'd240, 16'h0001};
			default: z = '0;
		endcase
		return z;
	endfunction

endpackage

>>> sv/tzpm_zone.sv
// ----------------------------------------------------------------------------
// Touch zone pad mapper zone unit
// Lays out one zone per cycle from the window geometry, in three stages.
// ----------------------------------------------------------------------------
module tzpm_zone (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              issue,
	input  logic [3:0]        zidx,
	input  tzpm_pkg::geo_t    geo,
	output tzpm_pkg::zs1_t    zs1,
	output tzpm_pkg::zs3_t    zs3
);

	tzpm_pkg::zone_t    z;
	logic [25:0]        xb;
	logic [25:0]        yb;
	logic signed [25:0] kx;
	logic signed [25:0] ky;
	logic [21:0]        hwm;
	logic [21:0]        hhm;
	tzpm_pkg::zs1_t     zs1_q;
	tzpm_pkg::zs3_t     zs_s2;
	tzpm_pkg::zs3_t     zs_s3;

	always_comb begin
		z = tzpm_pkg::zone_get(zidx);
		case (z.xbase)
			tzpm_pkg::XB_FULL: xb = geo.w10k;
			tzpm_pkg::XB_HALF: xb = {1'b0, geo.w5k};
			default:           xb = '0;
		endcase
		yb  = z.ybase ? geo.h10k : '0;
		kx  = z.xk * $signed({1'b0, geo.m});
		ky  = z.yk * $signed({1'b0, geo.m});
		hwm = z.hw * geo.m;
		hhm = z.hh * geo.m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zs1_q <= '0;
			zs_s2 <= '0;
			zs_s3 <= '0;
		end else begin
			zs1_q.v    <= issue;
			zs1_q.cx   <= ($signed({6'b0, xb}) + 32'(kx)) <<< 4;
			zs1_q.cy   <= ($signed({6'b0, yb}) + 32'(ky)) <<< 4;
			zs1_q.hw   <= {hwm, 4'b0};
			zs1_q.hh   <= {hhm, 4'b0};
			zs1_q.rnd  <= z.rnd;
			zs1_q.bitm <= z.bitm;
			zs_s2.v    <= zs1_q.v;
			zs_s2.rnd  <= zs1_q.rnd;
			zs_s2.bitm <= zs1_q.bitm;
			zs_s2.r2   <= zs1_q.hw * zs1_q.hw;
			zs_s3      <= zs_s2;
		end
	end

	assign zs1 = zs1_q;
	assign zs3 = zs_s3;

endmodule

>>> sv/tzpm_cell.sv
// ----------------------------------------------------------------------------
// Touch zone pad mapper finger cell
// Holds one finger slot, hit-tests it against the broadcast zone and folds
// its pressed bits into the mask handed along the row.
// ----------------------------------------------------------------------------
module tzpm_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [63:0]    id_cmp,
	input  tzpm_pkg::wr_t  wr,
	input  logic [29:0]    x_wr,
	input  logic [29:0]    y_wr,
	input  logic           mclr,
	input  tzpm_pkg::zs1_t zs1,
	input  tzpm_pkg::zs3_t zs3,
	input  logic [15:0]    chain_in,
	output logic [15:0]    chain_out,
	output logic           match,
	output logic           active
);

	logic               act_q;
	logic [63:0]        id_q;
	logic [29:0]        x_q;
	logic [29:0]        y_q;
	logic [15:0]        mask_q;
	logic signed [31:0] dx_s2;
	logic signed [31:0] dy_s2;
	logic               inb_s2;
	logic [51:0]        sqx_s3;
	logic [51:0]        sqy_s3;
	logic               inb_s3;
	logic signed [31:0] dx;
	logic signed [31:0] dy;
	logic signed [31:0] hw_s;
	logic signed [31:0] hh_s;
	logic               inb;
	logic [31:0]        ax;
	logic [31:0]        ay;
	logic               hit;

	always_comb begin
		hw_s = $signed({6'b0, zs1.hw});
		hh_s = $signed({6'b0, zs1.hh});
		dx   = $signed({2'b0, x_q}) - zs1.cx;
		dy   = $signed({2'b0, y_q}) - zs1.cy;
		inb  = (dx <= hw_s) && (dx >= -hw_s) && (dy <= hh_s) && (dy >= -hh_s);
		ax   = dx_s2[31] ? 32'(-dx_s2) : 32'(dx_s2);
		ay   = dy_s2[31] ? 32'(-dy_s2) : 32'(dy_s2);
		hit  = inb_s3 && (!zs3.rnd ||
			(({1'b0, sqx_s3} + {1'b0, sqy_s3}) <= {1'b0, zs3.r2}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (wr.set_act) begin
			act_q <= 1'b1;
		end else if (wr.clr_act) begin
			act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.ident) begin
			id_q <= id_cmp;
		end
		if (wr.pos) begin
			x_q <= x_wr;
			y_q <= y_wr;
		end
		dx_s2  <= dx;
		dy_s2  <= dy;
		inb_s2 <= inb;
		sqx_s3 <= ax[25:0] * ax[25:0];
		sqy_s3 <= ay[25:0] * ay[25:0];
		inb_s3 <= inb_s2;
		if (mclr) begin
			mask_q <= '1;
		end else if (zs3.v && act_q && hit) begin
			mask_q <= mask_q & ~zs3.bitm;
		end
	end

	assign chain_out = chain_in & mask_q;
	assign match     = act_q && (id_q == id_cmp);
	assign active    = act_q;

endmodule

>>> sv/touch_zone_pad_mapper_unit.sv
// ----------------------------------------------------------------------------
// Touch zone pad mapper
// Tracks touching fingers in a row of slot cells and turns them into an
// active-low pad mask by testing every finger against fourteen zones.
// ----------------------------------------------------------------------------
// An accepted start steps through the calc, write, zone, drain and finish states,
// and start is taken only while idle; busy drops in the cycle of the result.
// Done pulses after finish. The sequence is set by the fourteen zone passes
// through the cell row and the three-stage zone test pipeline behind them.
// Reset clears all slots, restores the window registers to 1920 by 1080 and
// clears the external pad flag. The receiver cannot stall the result.
module touch_zone_pad_mapper_unit #(
	parameter int FINGER_SLOTS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  operation,
	input  logic [63:0] finger_id,
	input  logic [15:0] x_frac,
	input  logic [15:0] y_frac,
	output logic [15:0] pad_mask,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	tzpm_pkg::state_t st_q;
	tzpm_pkg::state_t st_d;
	logic [3:0]       zc_q;
	logic             zc_clr;
	logic             issue;
	logic             mclr;
	logic             wr_go;
	logic             fin;

	logic [11:0]      width_q;
	logic [11:0]      height_q;
	logic             extpad_q;

	tzpm_pkg::op_t    op_q;
	logic [63:0]      id_q;
	logic [15:0]      xf_q;
	logic [15:0]      yf_q;
	logic [19:0]      x_q;
	logic [19:0]      y_q;
	tzpm_pkg::geo_t   geo_q;
	logic [27:0]      xp;
	logic [27:0]      yp;
	logic [11:0]      mval;
	logic [29:0]      x625;
	logic [29:0]      y625;

	logic [15:0]      pad_mask_q;
	logic             done_q;

	logic [FINGER_SLOTS-1:0] match_v;
	logic [FINGER_SLOTS-1:0] act_v;
	logic [FINGER_SLOTS-1:0] mfirst;
	logic [FINGER_SLOTS-1:0] ffirst;
	logic [FINGER_SLOTS-1:0] tgt;
	logic                    mfound;
	logic                    ffound;
	tzpm_pkg::wr_t           wr_v [FINGER_SLOTS];
	logic [15:0]             chain [FINGER_SLOTS+1];

	tzpm_pkg::zs1_t   zs1;
	tzpm_pkg::zs3_t   zs3;

	logic             cfg_wr;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd1920;
			height_q <= 12'd1080;
			extpad_q <= 1'b0;
		end else if (cfg_wr) begin
			case (tzpm_pkg::reg_idx_t'(paddr[3:2]))
				tzpm_pkg::REG_WIDTH:  width_q  <= pwdata[11:0];
				tzpm_pkg::REG_HEIGHT: height_q <= pwdata[11:0];
				tzpm_pkg::REG_EXTPAD: extpad_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (tzpm_pkg::reg_idx_t'(paddr[3:2]))
			tzpm_pkg::REG_WIDTH:  prdata = {20'b0, width_q};
			tzpm_pkg::REG_HEIGHT: prdata = {20'b0, height_q};
			tzpm_pkg::REG_EXTPAD: prdata = {31'b0, extpad_q};
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= tzpm_pkg::ST_IDLE;
			zc_q   <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			zc_q   <= zc_clr ? 4'd0 : zc_q + 4'd1;
			done_q <= fin;
		end
	end

	always_comb begin
		st_d   = st_q;
		zc_clr = 1'b1;
		issue  = 1'b0;
		mclr   = 1'b0;
		wr_go  = 1'b0;
		fin    = 1'b0;
		case (st_q)
			tzpm_pkg::ST_IDLE: begin
				if (start) begin
					st_d = tzpm_pkg::ST_CALC;
				end
			end
			tzpm_pkg::ST_CALC: begin
				st_d = tzpm_pkg::ST_WRITE;
			end
			tzpm_pkg::ST_WRITE: begin
				wr_go = 1'b1;
				mclr  = 1'b1;
				st_d  = tzpm_pkg::ST_ZONE;
			end
			tzpm_pkg::ST_ZONE: begin
				issue  = 1'b1;
				zc_clr = 1'b0;
				if (zc_q == 4'(tzpm_pkg::ZONE_COUNT - 1)) begin
					zc_clr = 1'b1;
					st_d   = tzpm_pkg::ST_DRAIN;
				end
			end
			tzpm_pkg::ST_DRAIN: begin
				zc_clr = 1'b0;
				if (zc_q == 4'd2) begin
					zc_clr = 1'b1;
					st_d   = tzpm_pkg::ST_FINISH;
				end
			end
			tzpm_pkg::ST_FINISH: begin
				fin  = 1'b1;
				st_d = tzpm_pkg::ST_IDLE;
			end
			default: begin
				st_d = tzpm_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (st_q != tzpm_pkg::ST_IDLE);

	always_comb begin
		xp   = xf_q * width_q;
		yp   = yf_q * height_q;
		mval = (width_q < height_q) ? width_q : height_q;
		x625 = x_q * 10'd625;
		y625 = y_q * 10'd625;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q <= tzpm_pkg::op_t'(operation);
			id_q <= finger_id;
			xf_q <= x_frac;
			yf_q <= y_frac;
		end
		if (st_q == tzpm_pkg::ST_CALC) begin
			x_q        <= xp[27:8];
			y_q        <= yp[27:8];
			geo_q.w10k <= width_q * 14'd10000;
			geo_q.w5k  <= width_q * 13'd5000;
			geo_q.h10k <= height_q * 14'd10000;
			geo_q.m    <= mval;
		end
		if (fin) begin
			pad_mask_q <= extpad_q ? 16'hffff : chain[FINGER_SLOTS];
		end
	end

	always_comb begin
		mfound = 1'b0;
		ffound = 1'b0;
		for (int i = 0; i < FINGER_SLOTS; i++) begin
			mfirst[i] = match_v[i] && !mfound;
			ffirst[i] = !act_v[i] && !ffound;
			mfound    = mfound || match_v[i];
			ffound    = ffound || !act_v[i];
		end
		tgt = mfound ? mfirst : ffirst;
		for (int i = 0; i < FINGER_SLOTS; i++) begin
			wr_v[i].ident   = wr_go && (op_q == tzpm_pkg::OP_DOWN) && tgt[i];
			wr_v[i].set_act = wr_go && (op_q == tzpm_pkg::OP_DOWN) && tgt[i];
			wr_v[i].pos     = wr_go && (((op_q == tzpm_pkg::OP_DOWN) && tgt[i]) ||
				((op_q == tzpm_pkg::OP_MOTION) && mfirst[i]));
			wr_v[i].clr_act = wr_go && (op_q == tzpm_pkg::OP_UP) && mfirst[i];
		end
	end

	tzpm_zone u_zone (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.zidx   (zc_q),
		.geo    (geo_q),
		.zs1    (zs1),
		.zs3    (zs3)
	);

	assign chain[0] = '1;

	for (genvar g = 0; g < FINGER_SLOTS; g++) begin : g_cell
		tzpm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.id_cmp    (id_q),
			.wr        (wr_v[g]),
			.x_wr      (x625),
			.y_wr      (y625),
			.mclr      (mclr),
			.zs1       (zs1),
			.zs3       (zs3),
			.chain_in  (chain[g]),
			.chain_out (chain[g+1]),
			.match     (match_v[g]),
			.active    (act_v[g])
		);
	end

	assign pad_mask = pad_mask_q;
	assign done     = done_q;

endmodule

>>> sv/tzpm_checker.sv
// ----------------------------------------------------------------------------
// Touch zone pad mapper checker
// Port-level checks on the command handshake and the result beat.
// ----------------------------------------------------------------------------
module tzpm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [15:0] pad_mask
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Accepted event did not raise busy.");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result beat lasted more than one cycle.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("Busy dropped without a result beat.");

	a_fixed_bits: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> pad_mask[1] && pad_mask[2])
		else $error("Pad mask shows an unmapped button pressed.");

endmodule

bind touch_zone_pad_mapper_unit tzpm_checker u_tzpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.pad_mask (pad_mask)
);
